@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the frame pacer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/fpsw_pkg.sv @@
// Shared types and constants of the frame pacer with sliding window.
`default_nettype none

package fpsw_pkg;

   // Field widths
   localparam int TIME_W     = 32;
   localparam int WAIT_W     = 31;
   localparam int RATE_W     = 24;
   localparam int FPS_W      = 10;
   localparam int INTERVAL_W = 8;
   localparam int WINLEN_W   = 8;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET_FPS      = 2'd0,
      CSR_UPDATE_INTERVAL = 2'd1,
      CSR_WINDOW_LEN      = 2'd2
   } csr_idx_type;

   // Register reset values
   localparam logic [FPS_W-1:0]      TARGET_FPS_RST      = 10'd60;
   localparam logic [INTERVAL_W-1:0] UPDATE_INTERVAL_RST = 8'd60;
   localparam logic [WINLEN_W-1:0]   WINDOW_LEN_RST      = 8'd120;

   // Window sizing
   localparam int WINDOW_MAX_DEF = 128;
   localparam logic [WINLEN_W-1:0] WIN_MIN = 8'd2;

   // Arithmetic constants
   localparam int MS_PER_S   = 1000;
   localparam int RATE_SCALE = 200000;   // 2 * 100000 for round-half-up
   localparam logic [RATE_W-1:0] RATE_MAX = 24'hFF_FFFF;

   // Shared divider: 33-bit quotient covers the rate numerator for any window size
   localparam int RATE_DIV_W = 33;
   localparam int DIV_STEP_W = 6;

   typedef struct packed {
      logic                  start;
      logic [DIV_STEP_W-1:0] steps;
   } div_cmd_type;

endpackage

`default_nettype wire

@@ rtl/core/fpsw_if.sv @@
// Channel interfaces of the frame pacer: frame requests, results, register writes.
`default_nettype none

interface fpsw_req_if;
   logic                          valid;
   logic                          ready;
   logic [fpsw_pkg::TIME_W-1:0]   query_time_ms;
   logic [fpsw_pkg::TIME_W-1:0]   stamp_time_ms;

   modport source (output valid, query_time_ms, stamp_time_ms, input ready);
   modport sink   (input valid, query_time_ms, stamp_time_ms, output ready);
endinterface

interface fpsw_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [fpsw_pkg::WAIT_W-1:0]   wait_ms;
   logic [fpsw_pkg::RATE_W-1:0]   rate_centi_fps;
   logic                          rate_updated;

   modport source (output valid, wait_ms, rate_centi_fps, rate_updated, input ready);
   modport sink   (input valid, wait_ms, rate_centi_fps, rate_updated, output ready);
endinterface

interface fpsw_csr_if;
   logic                            valid;
   logic                            ready;
   logic [fpsw_pkg::CSR_IDX_W-1:0]  idx;
   logic [fpsw_pkg::CSR_DATA_W-1:0] wdata;

   modport source (output valid, idx, wdata, input ready);
   modport sink   (input valid, idx, wdata, output ready);
endinterface

`default_nettype wire

@@ rtl/core/fpsw_ram.sv @@
// Generic single-port synchronous RAM with registered read data.
`default_nettype none

module fpsw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // One access per cycle: write, or read into the output register
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata <= mem_ff[addr];
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/fpsw_div.sv @@
// Bit-serial restoring divider shared by the pacing and rate computations.
`default_nettype none

module fpsw_div (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire fpsw_pkg::div_cmd_type               cmd,
   input  wire logic [fpsw_pkg::RATE_DIV_W-1:0]     num,
   input  wire logic [fpsw_pkg::RATE_DIV_W-1:0]     den,
   output logic                                     busy,
   output logic      [fpsw_pkg::RATE_DIV_W-1:0]     quo
);

   localparam int W = fpsw_pkg::RATE_DIV_W;

   logic                            busy_ff, busy_in;
   logic [fpsw_pkg::DIV_STEP_W-1:0] left_ff, left_in;
   logic [W-1:0]                    num_ff, num_in;
   logic [W-1:0]                    den_ff, den_in;
   logic [W-1:0]                    rem_ff, rem_in;
   logic [W-1:0]                    quo_ff, quo_in;
   logic [W:0]                      rem_sh;
   logic                            fits;

   // One quotient bit per cycle, numerator consumed MSB first
   always_comb begin
      busy_in = busy_ff;
      left_in = left_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      rem_sh  = {rem_ff, num_ff[W-1]};
      fits    = rem_sh >= {1'b0, den_ff};
      if (cmd.start) begin
         busy_in = 1'b1;
         left_in = cmd.steps;
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
         quo_in  = '0;
      end else if (busy_ff) begin
         num_in  = {num_ff[W-2:0], 1'b0};
         rem_in  = fits ? W'(rem_sh - {1'b0, den_ff}) : rem_sh[W-1:0];
         quo_in  = {quo_ff[W-2:0], fits};
         left_in = left_ff - 1'b1;
         if (left_ff == fpsw_pkg::DIV_STEP_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (reset) begin
         busy_ff <= 1'b0;
         left_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         left_ff <= left_in;
      end
   end

   assign busy = busy_ff;
   assign quo  = quo_ff;

endmodule

`default_nettype wire

@@ rtl/core/frame_pacer_sliding_window.sv @@
// Frame pacer: per frame, the wait until its slot and a sliding-window rate measurement.
//
// Each request transfer is one frame; it yields exactly one response transfer.
// The frame stamps live in a single-port RAM of WINDOW_MAX entries; ring head,
// stamp count, frame counter and the measured rate are registers. Frames are
// handled one at a time: a plain frame passes S_WDIV (pacing divide and stamp
// store), S_CHECK and S_DONE; a frame that triggers a rate measurement also
// passes S_RREAD and, unless the window spans no time, S_RDIV. Both divisions
// run on the shared bit-serial divider, which produces one quotient bit per cycle
// (WAIT_NUM_W bits for the pacing delay, 33 bits for the rate). The next
// request is taken as soon as the previous response is loaded into the output
// register, even while that response still waits to be taken. Registers may be
// written at any time the block is idle; the write port is always ready.
`default_nettype none
`include "assert_macros.svh"

module frame_pacer_sliding_window #(
   parameter int WINDOW_MAX = fpsw_pkg::WINDOW_MAX_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   fpsw_req_if.sink        req_if,
   fpsw_rsp_if.source      rsp_if,
   fpsw_csr_if.sink        csr_if
);

   localparam int HEAD_W     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
   localparam int WAIT_NUM_W = $clog2(fpsw_pkg::MS_PER_S * WINDOW_MAX + 1);
   localparam int DW         = fpsw_pkg::RATE_DIV_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_WDIV,
      S_CHECK,
      S_RREAD,
      S_RDIV,
      S_DONE
   } state_type;

   // Control state
   state_type                         state_ff, state_in;
   logic [fpsw_pkg::FPS_W-1:0]        target_fps_ff, target_fps_in;
   logic [fpsw_pkg::INTERVAL_W-1:0]   interval_ff, interval_in;
   logic [fpsw_pkg::WINLEN_W-1:0]     window_len_ff, window_len_in;
   logic [HEAD_W-1:0]                 head_ff, head_in;
   logic [CNT_W-1:0]                  count_ff, count_in;
   logic [7:0]                        frame_ff, frame_in;
   logic [fpsw_pkg::RATE_W-1:0]       rate_ff, rate_in;
   logic                              rsp_valid_ff, rsp_valid_in;

   // Payload
   logic [fpsw_pkg::TIME_W-1:0]       query_ff, query_in;
   logic [fpsw_pkg::TIME_W-1:0]       stamp_ff, stamp_in;
   logic [CNT_W-1:0]                  win_ff, win_in;
   logic [fpsw_pkg::WAIT_W-1:0]       wait_ff, wait_in;
   logic                              updated_ff, updated_in;
   logic [DW-1:0]                     prod_ff, prod_in;
   logic [fpsw_pkg::WAIT_W-1:0]       rsp_wait_ff, rsp_wait_in;
   logic [fpsw_pkg::RATE_W-1:0]       rsp_rate_ff, rsp_rate_in;
   logic                              rsp_upd_ff, rsp_upd_in;

   // RAM and divider hookup
   logic                              ram_en;
   logic                              ram_we;
   logic [HEAD_W-1:0]                 ram_addr;
   logic [fpsw_pkg::TIME_W-1:0]       ram_wdata;
   logic [fpsw_pkg::TIME_W-1:0]       ram_rdata;
   fpsw_pkg::div_cmd_type             div_cmd;
   logic [DW-1:0]                     div_num;
   logic [DW-1:0]                     div_den;
   logic                              div_busy;
   logic [DW-1:0]                     div_quo;

   // Combinational helpers
   logic [CNT_W-1:0]                  win_eff;
   logic [fpsw_pkg::FPS_W-1:0]        fps_eff;
   logic [WAIT_NUM_W-1:0]             wait_num;
   logic [fpsw_pkg::TIME_W-1:0]       diff;
   logic [CNT_W:0]                    new_cnt;
   logic [fpsw_pkg::TIME_W-1:0]       span;

   // (base + ofs) modulo WINDOW_MAX, with base below and ofs at most WINDOW_MAX
   function automatic logic [HEAD_W-1:0] ring_wrap(input logic [HEAD_W-1:0] base,
                                                   input logic [CNT_W-1:0]  ofs);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(base) + (CNT_W+1)'(ofs);
      if (sum >= (CNT_W+1)'(WINDOW_MAX)) begin
         sum = sum - (CNT_W+1)'(WINDOW_MAX);
      end
      return sum[HEAD_W-1:0];
   endfunction

   fpsw_ram #(
      .WIDTH (fpsw_pkg::TIME_W),
      .DEPTH (WINDOW_MAX)
   ) u_ring (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   fpsw_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .quo   (div_quo)
   );

   // Effective window length and target rate
   always_comb begin
      if (window_len_ff < fpsw_pkg::WIN_MIN) begin
         win_eff = CNT_W'(fpsw_pkg::WIN_MIN);
      end else if (32'(window_len_ff) > 32'(WINDOW_MAX)) begin
         win_eff = CNT_W'(WINDOW_MAX);
      end else begin
         win_eff = CNT_W'(window_len_ff);
      end
      fps_eff = (target_fps_ff == '0) ? fpsw_pkg::FPS_W'(1) : target_fps_ff;
   end

   assign wait_num = WAIT_NUM_W'(fpsw_pkg::MS_PER_S) * WAIT_NUM_W'(count_ff);
   assign diff     = ram_rdata + div_quo[fpsw_pkg::TIME_W-1:0] - query_ff;
   assign new_cnt  = (CNT_W+1)'(count_ff) + (CNT_W+1)'(1);
   assign span     = stamp_ff - ram_rdata;

   // Sequencer: read oldest, divide, store stamp, optionally measure rate
   always_comb begin
      state_in      = state_ff;
      target_fps_in = target_fps_ff;
      interval_in   = interval_ff;
      window_len_in = window_len_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      frame_in      = frame_ff;
      rate_in       = rate_ff;
      rsp_valid_in  = rsp_valid_ff;
      query_in      = query_ff;
      stamp_in      = stamp_ff;
      win_in        = win_ff;
      wait_in       = wait_ff;
      updated_in    = updated_ff;
      prod_in       = prod_ff;
      rsp_wait_in   = rsp_wait_ff;
      rsp_rate_in   = rsp_rate_ff;
      rsp_upd_in    = rsp_upd_ff;
      ram_en        = 1'b0;
      ram_we        = 1'b0;
      ram_addr      = head_ff;
      ram_wdata     = stamp_ff;
      div_cmd       = '0;
      div_num       = '0;
      div_den       = '0;

      // Register writes
      if (csr_if.valid) begin
         unique case (csr_if.idx)
            fpsw_pkg::CSR_TARGET_FPS:      target_fps_in = csr_if.wdata;
            fpsw_pkg::CSR_UPDATE_INTERVAL: interval_in   = csr_if.wdata[7:0];
            fpsw_pkg::CSR_WINDOW_LEN:      window_len_in = csr_if.wdata[7:0];
            default: ;
         endcase
      end

      // Response leaves the output register
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               query_in      = req_if.query_time_ms;
               stamp_in      = req_if.stamp_time_ms;
               frame_in      = frame_ff + 8'd1;
               win_in        = win_eff;
               ram_en        = 1'b1;
               ram_addr      = head_ff;
               div_cmd.start = 1'b1;
               div_cmd.steps = fpsw_pkg::DIV_STEP_W'(WAIT_NUM_W);
               div_num       = DW'(wait_num) << (DW - WAIT_NUM_W);
               div_den       = DW'(fps_eff);
               state_in      = S_WDIV;
            end
         end
         S_WDIV: begin
            if (!div_busy) begin
               // Pacing delay, negative results or an empty window clamp to zero
               if (count_ff != '0 && !diff[fpsw_pkg::TIME_W-1]) begin
                  wait_in = diff[fpsw_pkg::WAIT_W-1:0];
               end else begin
                  wait_in = '0;
               end
               // Store the stamp and slide the window
               ram_en    = 1'b1;
               ram_we    = 1'b1;
               ram_addr  = ring_wrap(head_ff, count_ff);
               ram_wdata = stamp_ff;
               if (new_cnt > (CNT_W+1)'(win_ff)) begin
                  head_in  = ring_wrap(head_ff, CNT_W'(new_cnt - (CNT_W+1)'(win_ff)));
                  count_in = win_ff;
               end else begin
                  count_in = CNT_W'(new_cnt);
               end
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            prod_in    = DW'(fpsw_pkg::RATE_SCALE) * DW'(count_ff - CNT_W'(1));
            updated_in = 1'b0;
            state_in   = S_DONE;
            if (frame_ff == interval_ff) begin
               frame_in = '0;
               if (count_ff >= win_ff) begin
                  ram_en   = 1'b1;
                  ram_addr = head_ff;
                  state_in = S_RREAD;
               end
            end
         end
         S_RREAD: begin
            if (span == '0) begin
               state_in = S_DONE;
            end else begin
               div_cmd.start = 1'b1;
               div_cmd.steps = fpsw_pkg::DIV_STEP_W'(DW);
               div_num       = prod_ff + DW'(span);
               div_den       = DW'({span, 1'b0});
               state_in      = S_RDIV;
            end
         end
         S_RDIV: begin
            if (!div_busy) begin
               if (|div_quo[DW-1:fpsw_pkg::RATE_W]) begin
                  rate_in = fpsw_pkg::RATE_MAX;
               end else begin
                  rate_in = div_quo[fpsw_pkg::RATE_W-1:0];
               end
               updated_in = 1'b1;
               state_in   = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_wait_in  = wait_ff;
               rsp_rate_in  = rate_ff;
               rsp_upd_in   = updated_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      query_ff    <= query_in;
      stamp_ff    <= stamp_in;
      win_ff      <= win_in;
      wait_ff     <= wait_in;
      updated_ff  <= updated_in;
      prod_ff     <= prod_in;
      rsp_wait_ff <= rsp_wait_in;
      rsp_rate_ff <= rsp_rate_in;
      rsp_upd_ff  <= rsp_upd_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         target_fps_ff <= fpsw_pkg::TARGET_FPS_RST;
         interval_ff   <= fpsw_pkg::UPDATE_INTERVAL_RST;
         window_len_ff <= fpsw_pkg::WINDOW_LEN_RST;
         head_ff       <= '0;
         count_ff      <= '0;
         frame_ff      <= '0;
         rate_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         target_fps_ff <= target_fps_in;
         interval_ff   <= interval_in;
         window_len_ff <= window_len_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         frame_ff      <= frame_in;
         rate_ff       <= rate_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign req_if.ready          = (state_ff == S_IDLE);
   assign csr_if.ready          = 1'b1;
   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.wait_ms        = rsp_wait_ff;
   assign rsp_if.rate_centi_fps = rsp_rate_ff;
   assign rsp_if.rate_updated   = rsp_upd_ff;

   // Checks
   `ASSERT_NEXT(a_accept_starts_div, clock, reset, req_if.valid && req_if.ready, div_busy && state_ff == S_WDIV, "frame transfer did not start the divider")
   `ASSERT_IMPL(a_div_start_idle, clock, reset, div_cmd.start, !div_busy, "divider restarted while busy")
   `ASSERT_IMPL(a_ring_bounds, clock, reset, 1'b1, 32'(count_ff) <= 32'(WINDOW_MAX) && 32'(head_ff) < 32'(WINDOW_MAX), "ring head or stamp count out of range")
   `ASSERT_IMPL(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == S_DONE, "response raised outside the done state")

endmodule

`default_nettype wire
